// ----- design/tdf_pkg.sv -----
// shared types, constants and helpers of the trigger record deframer
package tdf_pkg;

    localparam int WORD_BITS      = 80;
    localparam int BUNCH_ID_BITS  = 12;
    localparam int REC_MAX_BITS   = 76;
    localparam int LEN_W          = 7;
    localparam int PAYLOAD_BITS   = 64;
    localparam int ORBIT_BITS     = 32;
    localparam int WORD_BYTES     = 10;
    localparam int CNT_W          = 3;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic [LEN_W-1:0] REC_MIN_LEN = 7'd16;
    localparam logic [LEN_W-1:0] REC_MAX_LEN = 7'd76;
    localparam logic [LEN_W-1:0] IR_LEN_RST  = 7'd60;
    localparam logic [LEN_W-1:0] CLS_LEN_RST = 7'd76;

    localparam logic [CNT_W-1:0] MAX_RESULTS = 3'd6;

    localparam logic [3:0] SLOT_LAST_POS = 4'd15;
    localparam logic [3:0] WORD_LAST_POS = 4'd9;

    // register index is paddr[2]
    localparam logic REG_IR    = 1'b0;
    localparam logic REG_CLASS = 1'b1;

    localparam logic [WORD_BITS-1:0] WORD_ONE = {{(WORD_BITS-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [7:0]            payload_byte;
        logic                  page_start;
        logic [ORBIT_BITS-1:0] page_orbit;
        logic                  link_is_class;
    } tdf_in_t;

    typedef struct packed {
        logic [BUNCH_ID_BITS-1:0] bunch_id;
        logic [PAYLOAD_BITS-1:0]  record_payload;
        logic [ORBIT_BITS-1:0]    record_orbit;
        logic                     record_is_class;
        logic                     last_of_word;
    } tdf_out_t;

    // one finished word handed to the gearbox
    typedef struct packed {
        logic [WORD_BITS-1:0]  word;
        logic [ORBIT_BITS-1:0] orbit;
        logic                  is_class;
        logic [LEN_W-1:0]      len;
    } tdf_job_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v < REC_MIN_LEN)
            r = REC_MIN_LEN;
        else if (v > REC_MAX_LEN)
            r = REC_MAX_LEN;
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- design/tdf_shift_unit.sv -----
// shared shift unit: takes the next slice of the word and merges it above the leftover
module tdf_shift_unit (
    input  logic [tdf_pkg::WORD_BITS-1:0] word,
    input  logic [tdf_pkg::WORD_BITS-1:0] left_bits,
    input  logic [tdf_pkg::LEN_W-1:0]     take,
    input  logic [tdf_pkg::LEN_W-1:0]     left_cnt,
    output logic [tdf_pkg::WORD_BITS-1:0] rec,
    output logic [tdf_pkg::WORD_BITS-1:0] rest
);
    import tdf_pkg::*;

    logic [WORD_BITS-1:0] mask;

    assign mask = (WORD_ONE << take) - WORD_ONE;
    assign rec  = left_bits | ((word & mask) << left_cnt);
    assign rest = word >> take;

endmodule

// ----- design/tdf_gearbox.sv -----
// gearbox sequencer: cuts a word, a record per cycle unless stalled; holds leftover
module tdf_gearbox (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              left_clear,
    input  tdf_pkg::tdf_job_t job,
    input  logic              push_ready,
    output logic              push_valid,
    output tdf_pkg::tdf_out_t push_rec,
    output logic              busy
);
    import tdf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CUT   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [WORD_BITS-1:0]     word_reg, word_next;
    logic [WORD_BITS-1:0]     left_bits_reg, left_bits_next;
    logic [LEN_W-1:0]         left_cnt_reg, left_cnt_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [LEN_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ORBIT_BITS-1:0]    orbit_reg, orbit_next;
    logic                     class_reg, class_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [BUNCH_ID_BITS-1:0] pend_bid_reg, pend_bid_next;
    logic [PAYLOAD_BITS-1:0]  pend_pay_reg, pend_pay_next;

    logic [LEN_W-1:0]     take;
    logic [LEN_W-1:0]     pos_sum;
    logic [WORD_BITS-1:0] rec;
    logic [WORD_BITS-1:0] rest;
    logic                 emit;
    logic                 done;
    logic                 hold;

    assign take = len_reg - left_cnt_reg;

    tdf_shift_unit u_shift (
        .word      (word_reg),
        .left_bits (left_bits_reg),
        .take      (take),
        .left_cnt  (left_cnt_reg),
        .rec       (rec),
        .rest      (rest)
    );

    assign pos_sum = pos_reg + take;
    assign done    = pos_sum >= (LEN_W'(WORD_BITS) - len_reg);
    assign emit    = (rec[REC_MAX_BITS-1:BUNCH_ID_BITS] != '0) && (cnt_reg < MAX_RESULTS);
    // a second record found while the previous one cannot leave yet
    assign hold    = emit && pend_valid_reg && !push_ready;

    assign push_valid = ((state_reg == ST_CUT) && emit && pend_valid_reg)
                     || ((state_reg == ST_FLUSH) && pend_valid_reg);
    assign push_rec   = '{bunch_id:        pend_bid_reg,
                          record_payload:  pend_pay_reg,
                          record_orbit:    orbit_reg,
                          record_is_class: class_reg,
                          last_of_word:    (state_reg == ST_FLUSH)};
    assign busy       = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        left_bits_next  = left_bits_reg;
        left_cnt_next   = left_cnt_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        orbit_next      = orbit_reg;
        class_next      = class_reg;
        pend_valid_next = pend_valid_reg;
        pend_bid_next   = pend_bid_reg;
        pend_pay_next   = pend_pay_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (left_clear)
                begin
                    left_bits_next = '0;
                    left_cnt_next  = '0;
                end
                if (start)
                begin
                    word_next       = job.word;
                    len_next        = job.len;
                    orbit_next      = job.orbit;
                    class_next      = job.is_class;
                    pos_next        = '0;
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    // leftover longer than a record is dropped
                    if (left_cnt_reg > job.len)
                    begin
                        left_bits_next = '0;
                        left_cnt_next  = '0;
                    end
                    state_next = ST_CUT;
                end
            end
            ST_CUT:
            begin
                if (!hold)
                begin
                    if (emit)
                    begin
                        pend_valid_next = 1'b1;
                        pend_bid_next   = rec[BUNCH_ID_BITS-1:0];
                        pend_pay_next   = rec[REC_MAX_BITS-1:BUNCH_ID_BITS];
                        cnt_next        = cnt_reg + 1'b1;
                    end
                    word_next      = rest;
                    pos_next       = pos_sum;
                    left_bits_next = '0;
                    left_cnt_next  = '0;
                    if (done)
                    begin
                        left_bits_next = rest;
                        left_cnt_next  = LEN_W'(WORD_BITS) - pos_sum;
                        state_next     = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (push_ready)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            left_bits_reg  <= '0;
            left_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            left_bits_reg  <= left_bits_next;
            left_cnt_reg   <= left_cnt_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        len_reg      <= len_next;
        pos_reg      <= pos_next;
        orbit_reg    <= orbit_next;
        class_reg    <= class_next;
        pend_bid_reg <= pend_bid_next;
        pend_pay_reg <= pend_pay_next;
    end

endmodule

// ----- design/trigger_record_deframer_top.sv -----
// top level of the trigger record deframer: config registers, slot assembly, output register
// Takes one link byte per transfer. Bytes 0 to 9 of each 16-byte slot build an 80-bit word,
// least significant byte first; bytes 10 to 15 are dropped. Byte 9 hands the word to the
// gearbox, which cuts one record per cycle unless a found record must wait for the output,
// with a single shared shift unit (1 to 5 cuts depending on record length and leftover),
// and then hands over the last record; in_stall is high while the gearbox is busy. Records
// with an all-zero payload are dropped, at most six records of a word are kept, and
// last_of_word marks the final record of a word. A page start restarts the slot; a page
// start with a new orbit also drops the leftover bits carried between words. Record lengths
// are clamped to 16..76 bits. Register 0 (address 0x0) is the interaction record length,
// register 1 (address 0x4) the class record length; write them only while idle.
module trigger_record_deframer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tdf_pkg::tdf_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tdf_pkg::tdf_out_t              out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tdf_pkg::ADDR_W-1:0]     paddr,
    input  logic [tdf_pkg::DATA_W-1:0]     pwdata,
    output logic [tdf_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import tdf_pkg::*;

    logic [LEN_W-1:0]      ir_len_reg, ir_len_next;
    logic [LEN_W-1:0]      cls_len_reg, cls_len_next;
    logic [3:0]            pos_reg, pos_next;
    logic [WORD_BITS-1:0]  word_reg, word_next;
    logic [ORBIT_BITS-1:0] last_orbit_reg, last_orbit_next;
    logic                  orbit_seen_reg, orbit_seen_next;
    logic                  out_valid_reg, out_valid_next;
    tdf_out_t              out_data_reg, out_data_next;

    logic                  cfg_wr;
    logic                  in_fire;
    logic [3:0]            pos_eff;
    logic [WORD_BITS-1:0]  word_fill;
    logic                  gb_start;
    logic                  left_clear;
    tdf_job_t              job;
    logic                  gb_busy;
    logic                  push_valid;
    logic                  push_ready;
    tdf_out_t              push_rec;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        ir_len_next  = ir_len_reg;
        cls_len_next = cls_len_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_IR:    ir_len_next  = pwdata[LEN_W-1:0];
                REG_CLASS: cls_len_next = pwdata[LEN_W-1:0];
                default:   ir_len_next  = ir_len_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IR:    prdata = DATA_W'(ir_len_reg);
            REG_CLASS: prdata = DATA_W'(cls_len_reg);
            default:   prdata = '0;
        endcase
    end

    // slot assembly and orbit tracking
    assign in_stall = gb_busy;
    assign in_fire  = in_valid && !in_stall;
    assign pos_eff  = in_data.page_start ? 4'd0 : pos_reg;

    always_comb
    begin
        word_fill = in_data.page_start ? '0 : word_reg;
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            if (pos_eff == 4'(k))
                word_fill[k*8 +: 8] = in_data.payload_byte;
        end
    end

    always_comb
    begin
        pos_next        = pos_reg;
        word_next       = word_reg;
        last_orbit_next = last_orbit_reg;
        orbit_seen_next = orbit_seen_reg;
        gb_start        = 1'b0;
        left_clear      = 1'b0;
        if (in_fire)
        begin
            if (in_data.page_start)
            begin
                word_next = '0;
                if (!orbit_seen_reg)
                begin
                    orbit_seen_next = 1'b1;
                    last_orbit_next = in_data.page_orbit;
                end
                else if (in_data.page_orbit != last_orbit_reg)
                begin
                    left_clear      = 1'b1;
                    last_orbit_next = in_data.page_orbit;
                end
            end
            if (pos_eff == SLOT_LAST_POS)
                pos_next = 4'd0;
            else if (pos_eff > WORD_LAST_POS)
                pos_next = pos_eff + 4'd1;
            else
            begin
                pos_next  = pos_eff + 4'd1;
                word_next = word_fill;
                if (pos_eff == WORD_LAST_POS)
                begin
                    gb_start  = 1'b1;
                    word_next = '0;
                end
            end
        end
    end

    assign job = '{word:     word_fill,
                   orbit:    in_data.page_orbit,
                   is_class: in_data.link_is_class,
                   len:      clamp_len(in_data.link_is_class ? cls_len_reg : ir_len_reg)};

    tdf_gearbox u_gearbox (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (gb_start),
        .left_clear (left_clear),
        .job        (job),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .busy       (gb_busy)
    );

    // output register
    assign push_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (push_valid && push_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = push_rec;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_len_reg     <= IR_LEN_RST;
            cls_len_reg    <= CLS_LEN_RST;
            pos_reg        <= '0;
            word_reg       <= '0;
            last_orbit_reg <= '0;
            orbit_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ir_len_reg     <= ir_len_next;
            cls_len_reg    <= cls_len_next;
            pos_reg        <= pos_next;
            word_reg       <= word_next;
            last_orbit_reg <= last_orbit_next;
            orbit_seen_reg <= orbit_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // the final record of a word ends the cut
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready && push_rec.last_of_word) |=> !gb_busy)
        else $error("gearbox still busy after last record transfer");

    // a leftover clear never coincides with handing over a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !(gb_start && left_clear))
        else $error("leftover clear together with word start");

    // a word start puts the gearbox to work
    assert property (@(posedge clk) disable iff (!rst_n)
        gb_start |=> gb_busy)
        else $error("gearbox did not start on a completed word");

endmodule
